### hw/rtl/fat_pkg.sv
// Shared types and byte constants for the first-argument tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package fat_pkg;

  localparam int CHAR_W = 8;
  localparam int CAP_W  = 9;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SQUOTE  = 8'h27;
  localparam logic [CHAR_W-1:0] CH_DQUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7b;
  localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7d;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [1:0] {
    KIND_ARG   = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_DROP  = 2'd2,
    KIND_REST  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_ARG   = 2'd1,
    PH_TRAIL = 2'd2,
    PH_REST  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    kind_t             byte_kind;
    logic              out_last;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/fat_ifs.sv
// Channel interfaces for command bytes, classified bytes and the capacity register.
`timescale 1ns / 1ps
`default_nettype none

interface fat_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [fat_pkg::CHAR_W-1:0] in_char;
  logic                      in_last;
  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface fat_tok_if;
  logic                      valid;
  logic                      ready;
  logic [fat_pkg::CHAR_W-1:0] out_char;
  logic [1:0]                byte_kind;
  logic                      out_last;
  modport source (output valid, output out_char, output byte_kind, output out_last,
                  input ready);
  modport sink (input valid, input out_char, input byte_kind, input out_last,
                output ready);
endinterface

interface fat_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [fat_pkg::CAP_W-1:0] arg_capacity;
  modport source (output valid, output arg_capacity, input ready);
  modport sink (input valid, input arg_capacity, output ready);
endinterface

`default_nettype wire

### hw/rtl/fat_outbuf.sv
// Two-entry result buffer between the classifier and the output channel.
`timescale 1ns / 1ps
`default_nettype none

module fat_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fat_pkg::result_t push_data,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop_ready,
  output fat_pkg::result_t pop_data
);

  fat_pkg::result_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push_ok;
  logic             pop_ok;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];
  assign push_ok   = push && !full;
  assign pop_ok    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    ((count == 2'd0) || (count == 2'd2)) |-> (wr_ptr == rd_ptr))
    else $error("result buffer pointers disagree with count");

  a_push_held: assert property (@(posedge clk) disable iff (rst)
    (push_ok && !pop_ok) |=> pop_valid && (count == $past(count) + 2'd1))
    else $error("pushed word lost");

endmodule

`default_nettype wire

### hw/rtl/first_argument_tokenizer.sv
// Top level of the first-argument tokenizer.
`timescale 1ns / 1ps
`default_nettype none

// Takes one command-line byte per cycle while cmd.ready is high and returns one
// classified word per byte, in order. The classification and the line state
// (phase, closing byte, kept count) update in the same cycle the byte is
// accepted; results sit in a two-entry buffer, so cmd.ready drops only while two
// results wait at tok. Sustained rate is one byte per clock while tok.ready stays
// high. byte_kind: 0 kept argument byte, 1 closing delimiter, 2 discarded, 3 rest
// of line. A word with in_last set restarts the line state. arg_capacity (reset
// 256, clamped to MAX_CAPACITY) bounds kept argument bytes to arg_capacity minus
// one; write it only between lines while no results are pending.
module first_argument_tokenizer #(
  parameter int MAX_CAPACITY = 256
) (
  input  logic     clk,
  input  logic     rst,
  fat_cfg_if.sink   cfg,
  fat_cmd_if.sink   cmd,
  fat_tok_if.source tok
);

  localparam int CAP_MAX_REG = (1 << fat_pkg::CAP_W) - 1;
  localparam int CLAMP       = (MAX_CAPACITY < CAP_MAX_REG) ? MAX_CAPACITY : CAP_MAX_REG;
  localparam int CNT_W       = (CLAMP > 1) ? $clog2(CLAMP) : 1;
  localparam int CMP_W       = fat_pkg::CAP_W + 1;
  localparam logic [fat_pkg::CAP_W-1:0] CLAMP_V = fat_pkg::CAP_W'(CLAMP);

  logic [fat_pkg::CAP_W-1:0]  arg_capacity;
  fat_pkg::phase_t            phase;
  fat_pkg::phase_t            phase_next;
  logic [fat_pkg::CHAR_W-1:0] end_delim;
  logic [fat_pkg::CHAR_W-1:0] end_delim_next;
  logic [CNT_W-1:0]           kept_count;
  logic [CNT_W-1:0]           kept_count_next;

  logic [fat_pkg::CAP_W-1:0]  cap_eff;
  logic                       can_keep;
  logic                       cmd_fire;
  logic                       buf_full;
  fat_pkg::kind_t             kind;
  logic                       keep_byte;
  fat_pkg::result_t           res;
  fat_pkg::result_t           tok_data;
  logic [fat_pkg::CHAR_W-1:0] c;

  assign c        = cmd.in_char;
  assign cfg.ready = 1'b1;
  assign cmd.ready = !buf_full;
  assign cmd_fire  = cmd.valid && cmd.ready;

  assign cap_eff  = (arg_capacity > CLAMP_V) ? CLAMP_V : arg_capacity;
  assign can_keep = (CMP_W'(kept_count) + CMP_W'(1)) < CMP_W'(cap_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      arg_capacity <= fat_pkg::CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      arg_capacity <= cfg.arg_capacity;
    end
  end

  always_comb begin
    phase_next     = phase;
    end_delim_next = end_delim;
    keep_byte      = 1'b0;
    kind           = fat_pkg::KIND_DROP;
    case (phase)
      fat_pkg::PH_LEAD: begin
        if (c == fat_pkg::CH_SPACE) begin
          kind = fat_pkg::KIND_DROP;
        end else if (c inside {fat_pkg::CH_SQUOTE, fat_pkg::CH_DQUOTE,
                               fat_pkg::CH_PERCENT}) begin
          end_delim_next = c;
          phase_next     = fat_pkg::PH_ARG;
        end else if (c == fat_pkg::CH_LPAREN) begin
          end_delim_next = fat_pkg::CH_RPAREN;
          phase_next     = fat_pkg::PH_ARG;
        end else if (c == fat_pkg::CH_LBRACE) begin
          end_delim_next = fat_pkg::CH_RBRACE;
          phase_next     = fat_pkg::PH_ARG;
        end else begin
          end_delim_next = fat_pkg::CH_SPACE;
          phase_next     = fat_pkg::PH_ARG;
          keep_byte      = can_keep;
          kind           = can_keep ? fat_pkg::KIND_ARG : fat_pkg::KIND_DROP;
        end
      end
      fat_pkg::PH_ARG: begin
        if (c == end_delim) begin
          phase_next = fat_pkg::PH_TRAIL;
          kind       = fat_pkg::KIND_CLOSE;
        end else begin
          keep_byte = can_keep;
          kind      = can_keep ? fat_pkg::KIND_ARG : fat_pkg::KIND_DROP;
        end
      end
      fat_pkg::PH_TRAIL: begin
        if (c != fat_pkg::CH_SPACE) begin
          phase_next = fat_pkg::PH_REST;
          kind       = fat_pkg::KIND_REST;
        end
      end
      default: begin
        kind = fat_pkg::KIND_REST;
      end
    endcase
    kept_count_next = keep_byte ? (kept_count + CNT_W'(1)) : kept_count;
    // restart on the final byte of a line
    if (cmd.in_last) begin
      phase_next      = fat_pkg::PH_LEAD;
      end_delim_next  = fat_pkg::CH_SPACE;
      kept_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= fat_pkg::PH_LEAD;
      end_delim  <= fat_pkg::CH_SPACE;
      kept_count <= '0;
    end else if (cmd_fire) begin
      phase      <= phase_next;
      end_delim  <= end_delim_next;
      kept_count <= kept_count_next;
    end
  end

  assign res.out_char  = c;
  assign res.byte_kind = kind;
  assign res.out_last  = cmd.in_last;

  fat_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_fire),
    .push_data (res),
    .full      (buf_full),
    .pop_valid (tok.valid),
    .pop_ready (tok.ready),
    .pop_data  (tok_data)
  );

  assign tok.out_char  = tok_data.out_char;
  assign tok.byte_kind = tok_data.byte_kind;
  assign tok.out_last  = tok_data.out_last;

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd.in_last) |=> (phase == fat_pkg::PH_LEAD) && (kept_count == '0))
    else $error("line state not restarted after last byte");

  a_lead_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == fat_pkg::PH_LEAD) |-> (end_delim == fat_pkg::CH_SPACE) && (kept_count == '0))
    else $error("stale argument state while skipping leading spaces");

  a_count_only_on_arg: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && (kind != fat_pkg::KIND_ARG) && !cmd.in_last) |=> $stable(kept_count))
    else $error("kept count moved on a byte that was not kept");

endmodule

`default_nettype wire

### dv/fat_tok_checker.sv
// Checker for the first-argument tokenizer: tracks line state, predicts each word, compares.
`timescale 1ns / 1ps

module fat_tok_checker #(
  parameter int MAX_CAP = 256
) (
  input  logic clk,
  input  logic rst,
  fat_cfg_if   cfg,
  fat_cmd_if   cmd,
  fat_tok_if   tok,
  output int   mismatch_count,
  output int   pending_words,
  output int   checked_words
);
  import fat_pkg::*;

  result_t           expected_words[$];
  phase_t            line_phase;
  logic [CHAR_W-1:0] close_char;
  logic [CAP_W-1:0]  kept_bytes;
  logic [CAP_W-1:0]  cap_reg;
  int                errors;
  int                checked;

  function automatic void restart_line();
    line_phase = PH_LEAD;
    close_char = CH_SPACE;
    kept_bytes = '0;
  endfunction

  function automatic kind_t keep_or_drop();
    int cap_eff;
    cap_eff = (int'(cap_reg) > MAX_CAP) ? MAX_CAP : int'(cap_reg);
    if (int'(kept_bytes) + 1 < cap_eff) begin
      kept_bytes = kept_bytes + 1'b1;
      return KIND_ARG;
    end
    return KIND_DROP;
  endfunction

  function automatic result_t classify_byte(logic [CHAR_W-1:0] c, logic last);
    result_t r;
    kind_t   k;
    case (line_phase)
      PH_LEAD: begin
        if (c == CH_SPACE) begin
          k = KIND_DROP;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_PERCENT) begin
          close_char = c;
          line_phase = PH_ARG;
          k = KIND_DROP;
        end else if (c == CH_LPAREN) begin
          close_char = CH_RPAREN;
          line_phase = PH_ARG;
          k = KIND_DROP;
        end else if (c == CH_LBRACE) begin
          close_char = CH_RBRACE;
          line_phase = PH_ARG;
          k = KIND_DROP;
        end else begin
          close_char = CH_SPACE;
          line_phase = PH_ARG;
          k = keep_or_drop();
        end
      end
      PH_ARG: begin
        if (c == close_char) begin
          line_phase = PH_TRAIL;
          k = KIND_CLOSE;
        end else begin
          k = keep_or_drop();
        end
      end
      PH_TRAIL: begin
        if (c == CH_SPACE) begin
          k = KIND_DROP;
        end else begin
          line_phase = PH_REST;
          k = KIND_REST;
        end
      end
      default: begin
        k = KIND_REST;
      end
    endcase
    r.out_char  = c;
    r.byte_kind = k;
    r.out_last  = last;
    if (last) restart_line();
    return r;
  endfunction

  function automatic void report(string field, int want, int got);
    errors++;
    if (errors <= 40) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      restart_line();
      cap_reg = CAP_RESET;
      expected_words.delete();
    end else begin
      if (tok.valid && tok.ready) begin
        if (expected_words.size() == 0) begin
          report("unexpected word, out_char", 0, tok.out_char);
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (tok.out_char !== want.out_char) report("out_char", want.out_char, tok.out_char);
          if (tok.byte_kind !== want.byte_kind) begin
            report("byte_kind", want.byte_kind, tok.byte_kind);
          end
          if (tok.out_last !== want.out_last) report("out_last", want.out_last, tok.out_last);
        end
      end
      if (cmd.valid && cmd.ready) begin
        expected_words.insert(expected_words.size(), classify_byte(cmd.in_char, cmd.in_last));
      end
      if (cfg.valid && cfg.ready) cap_reg = cfg.arg_capacity;
    end
    mismatch_count <= errors;
    pending_words  <= expected_words.size();
    checked_words  <= checked;
  end

endmodule

### dv/tb_top.sv
// Testbench top for the first-argument tokenizer: clock, reset, command-line stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import fat_pkg::*;

  localparam int MAX_CAP = 256;
  localparam int LIMIT   = 400000;

  logic             clk;
  logic             rst;
  int               send_idle;
  int               recv_idle;
  int               bytes_sent;
  int               lines_sent;
  int               cap_writes;
  int               cycles;
  int               mismatches;
  int               pending;
  int               checked;
  logic [CHAR_W-1:0] line_q[$];
  logic [CAP_W-1:0]  cap_plan[8];

  fat_cmd_if cmd_if ();
  fat_tok_if tok_if ();
  fat_cfg_if cfg_if ();

  first_argument_tokenizer #(.MAX_CAPACITY(MAX_CAP)) u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .cmd (cmd_if),
    .tok (tok_if)
  );

  fat_tok_checker #(.MAX_CAP(MAX_CAP)) u_chk (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg_if),
    .cmd            (cmd_if),
    .tok            (tok_if),
    .mismatch_count (mismatches),
    .pending_words  (pending),
    .checked_words  (checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    tok_if.ready <= ($urandom_range(0, 99) >= recv_idle);
    if (cycles >= LIMIT) begin
      $display("[first_argument_tokenizer] ERROR");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] any_byte();
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  function automatic bit opens_arg(logic [CHAR_W-1:0] b);
    return b == CH_SPACE || b == CH_SQUOTE || b == CH_DQUOTE || b == CH_PERCENT ||
           b == CH_LPAREN || b == CH_LBRACE;
  endfunction

  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last);
    if ($urandom_range(0, 99) < send_idle) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle) @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.in_char <= c;
    cmd_if.in_last <= last;
    @(posedge clk);
    while (cmd_if.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [CHAR_W-1:0] bs[$]);
    foreach (bs[i]) send_byte(bs[i], i == bs.size() - 1);
    lines_sent++;
  endtask

  // hold the sender until every word has come back
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] v);
    wait_drained();
    cfg_if.valid        <= 1'b1;
    cfg_if.arg_capacity <= v;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    cfg_if.valid <= 1'b0;
    cap_writes++;
  endtask

  task automatic send_line();
    logic [CHAR_W-1:0] bytes_q[$];
    logic [CHAR_W-1:0] b;
    logic [CHAR_W-1:0] closer;
    int                sel;
    int                n;
    sel = $urandom_range(0, 19);
    if (sel < 2) begin
      n = $urandom_range(1, 12);
      repeat (n) bytes_q = {bytes_q, any_byte()};
    end else begin
      repeat ($urandom_range(0, 3)) bytes_q = {bytes_q, CH_SPACE};
      case ($urandom_range(0, 7))
        0: begin
          bytes_q = {bytes_q, CH_SQUOTE};
          closer = CH_SQUOTE;
        end
        1: begin
          bytes_q = {bytes_q, CH_DQUOTE};
          closer = CH_DQUOTE;
        end
        2: begin
          bytes_q = {bytes_q, CH_PERCENT};
          closer = CH_PERCENT;
        end
        3: begin
          bytes_q = {bytes_q, CH_LPAREN};
          closer = CH_RPAREN;
        end
        4: begin
          bytes_q = {bytes_q, CH_LBRACE};
          closer = CH_RBRACE;
        end
        default: begin
          do b = any_byte(); while (opens_arg(b));
          bytes_q = {bytes_q, b};
          closer = CH_SPACE;
        end
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 10);
      repeat (n) begin
        do b = any_byte(); while (b == closer);
        bytes_q = {bytes_q, b};
      end
      bytes_q = {bytes_q, closer};
      repeat ($urandom_range(0, 3)) bytes_q = {bytes_q, CH_SPACE};
      repeat ($urandom_range(0, 6)) bytes_q = {bytes_q, any_byte()};
      // cut the line short in any phase
      if (sel < 5) begin
        n = $urandom_range(1, bytes_q.size());
        bytes_q = bytes_q[0:n-1];
      end
    end
    send_bytes(bytes_q);
  endtask

  initial begin
    int target;
    send_idle = 23;
    recv_idle = 51;
    rst                 <= 1'b1;
    cmd_if.valid        <= 1'b0;
    cmd_if.in_char      <= '0;
    cmd_if.in_last      <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.arg_capacity <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    line_q = '{CH_SPACE, CH_SQUOTE, "x", CH_SPACE, "y", CH_SQUOTE, CH_SPACE, "r"};
    send_bytes(line_q);
    line_q = '{CH_DQUOTE, CH_DQUOTE};
    send_bytes(line_q);
    line_q = '{CH_LPAREN, "a", CH_RPAREN, "b"};
    send_bytes(line_q);
    line_q = '{CH_LBRACE, CH_RBRACE};
    send_bytes(line_q);
    line_q = '{CH_PERCENT, "q", CH_PERCENT};
    send_bytes(line_q);
    line_q = '{8'hff, 8'h01, CH_SPACE, 8'h80};
    send_bytes(line_q);
    line_q = '{"z"};
    send_bytes(line_q);
    line_q = '{CH_SPACE};
    send_bytes(line_q);

    cap_plan[0] = 9'd0;
    cap_plan[1] = 9'd1;
    cap_plan[2] = 9'd2;
    cap_plan[3] = 9'd511;
    cap_plan[4] = CAP_W'($urandom_range(3, 20));
    cap_plan[5] = 9'd257;
    cap_plan[6] = 9'd255;
    cap_plan[7] = CAP_W'($urandom_range(0, 511));

    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        send_idle = 23;
        recv_idle = 51;
      end else if (p < 6) begin
        send_idle = 51;
        recv_idle = 23;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_cap(cap_plan[p]);
      target = 200 * (p + 1);
      do send_line(); while (bytes_sent < target);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("tokenizer run: %0d lines, %0d bytes sent, %0d words checked", lines_sent,
             bytes_sent, checked);
    $display("capacity written %0d times, including 0, 1, 255 and values above the clamp",
             cap_writes);
    if (mismatches == 0) begin
      $display("[first_argument_tokenizer] OK");
    end else begin
      $display("[first_argument_tokenizer] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/fat_pkg.sv
hw/rtl/fat_ifs.sv
hw/rtl/fat_outbuf.sv
hw/rtl/first_argument_tokenizer.sv
dv/fat_tok_checker.sv
dv/tb_top.sv
